// ----- rtl/dsss_pkg.sv -----
// ----------------------------------------------------------------------------
// dsss_pkg
// Shared types, mode codes and chip sequences for the DSSS chip spreader.
// ----------------------------------------------------------------------------
`default_nettype none

package dsss_pkg;

	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned CHIP_W  = 32;
	localparam int unsigned COUNT_W = 6;
	localparam int unsigned MODE_W  = 2;
	localparam int unsigned IDX_W   = 3;

	// phy_mode register codes; the unused code runs as 32-chip O-QPSK
	localparam logic [MODE_W-1:0] PHY_MODE_BPSK   = 2'd0;
	localparam logic [MODE_W-1:0] PHY_MODE_SUBGHZ = 2'd1;
	localparam logic [MODE_W-1:0] PHY_MODE_WIDE   = 2'd2;
	localparam logic [MODE_W-1:0] PHY_MODE_RESET  = PHY_MODE_WIDE;

	localparam logic [COUNT_W-1:0] BPSK_CHIPS   = 6'd15;
	localparam logic [COUNT_W-1:0] SUBGHZ_CHIPS = 6'd16;
	localparam logic [COUNT_W-1:0] WIDE_CHIPS   = 6'd32;

	localparam logic [IDX_W-1:0] BPSK_LAST_IDX = 3'd7;
	localparam logic [IDX_W-1:0] OQPSK_LAST_IDX = 3'd1;

	localparam logic [CHIP_W-1:0] BPSK_SEQ0      = 32'h0000_09AF;
	localparam logic [CHIP_W-1:0] BPSK_SEQ1      = 32'h0000_7650;
	localparam logic [CHIP_W-1:0] WIDE_BASE      = 32'h744A_C39B;
	localparam logic [CHIP_W-1:0] WIDE_ODD_CHIPS = 32'hAAAA_AAAA;

	typedef enum logic [1:0] {
		KIND_BPSK   = 2'd0,
		KIND_SUBGHZ = 2'd1,
		KIND_WIDE   = 2'd2
	} kind_t;

	// one byte of work for the back end: BPSK carries the differentially
	// encoded bits, O-QPSK the raw byte
	typedef struct packed {
		kind_t             kind;
		logic [BYTE_W-1:0] syms;
	} entry_t;

	function automatic logic [CHIP_W-1:0] subghz_chips(input logic [3:0] sym);
		logic [CHIP_W-1:0] w;
		case (sym)
			4'd0:    w = 32'h0000_A47C;
			4'd1:    w = 32'h0000_91F2;
			4'd2:    w = 32'h0000_47CA;
			4'd3:    w = 32'h0000_1F29;
			4'd4:    w = 32'h0000_7CA4;
			4'd5:    w = 32'h0000_F291;
			4'd6:    w = 32'h0000_CA47;
			4'd7:    w = 32'h0000_291F;
			4'd8:    w = 32'h0000_0ED6;
			4'd9:    w = 32'h0000_3B58;
			4'd10:   w = 32'h0000_ED60;
			4'd11:   w = 32'h0000_B583;
			4'd12:   w = 32'h0000_D60E;
			4'd13:   w = 32'h0000_583B;
			4'd14:   w = 32'h0000_60ED;
			default: w = 32'h0000_83B5;
		endcase
		return w;
	endfunction

	// base rotated left by four chips per symbol, odd chips inverted above 7
	function automatic logic [CHIP_W-1:0] wide_chips(input logic [3:0] sym);
		logic [2*CHIP_W-1:0] dbl;
		logic [5:0]          hi;
		logic [CHIP_W-1:0]   w;
		dbl = {WIDE_BASE, WIDE_BASE};
		hi  = 6'd63 - {1'b0, sym[2:0], 2'b00};
		w   = dbl[hi -: CHIP_W];
		if (sym[3]) begin
			w = w ^ WIDE_ODD_CHIPS;
		end
		return w;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/dsss_front.sv -----
// ----------------------------------------------------------------------------
// dsss_front
// Holds the mode register, classifies each byte and applies the BPSK
// differential encoding before handing the byte to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module dsss_front (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [dsss_pkg::MODE_W-1:0]      cfg_data,
	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire logic [dsss_pkg::BYTE_W-1:0]      in_byte,
	input  wire logic                             in_frame_start,
	output logic                                  push_valid,
	input  wire logic                             push_ready,
	output dsss_pkg::entry_t                      push_data
);
	import dsss_pkg::*;

	logic [MODE_W-1:0] mode_q;
	logic              diff_q;
	logic              diff_base;
	logic [BYTE_W-1:0] enc;
	kind_t             kind;
	logic              accept;

	assign cfg_ready  = 1'b1;
	assign in_ready   = push_ready;
	assign push_valid = in_valid;
	assign accept     = in_valid && push_ready;

	always_comb begin
		case (mode_q)
			PHY_MODE_BPSK:   kind = KIND_BPSK;
			PHY_MODE_SUBGHZ: kind = KIND_SUBGHZ;
			default:         kind = KIND_WIDE;
		endcase
	end

	// running XOR over the byte, seeded by the carried differential bit or by zero at a frame start
	always_comb begin
		diff_base = in_frame_start ? 1'b0 : diff_q;
		enc[0]    = in_byte[0] ^ diff_base;
		for (int k = 1; k < BYTE_W; k++) begin
			enc[k] = in_byte[k] ^ enc[k-1];
		end
	end

	always_comb begin
		push_data.kind = kind;
		push_data.syms = (kind == KIND_BPSK) ? enc : in_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= PHY_MODE_RESET;
			diff_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				mode_q <= cfg_data;
			end
			if (accept) begin
				if (kind == KIND_BPSK) begin
					diff_q <= enc[BYTE_W-1];
				end else if (in_frame_start) begin
					diff_q <= 1'b0;
				end
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/dsss_queue.sv -----
// ----------------------------------------------------------------------------
// dsss_queue
// Small register FIFO between the classifying front and the chip back end.
// ----------------------------------------------------------------------------
`default_nettype none

module dsss_queue #(
	parameter int unsigned DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr_valid,
	output logic                  wr_ready,
	input  wire dsss_pkg::entry_t wr_data,
	output logic                  rd_valid,
	input  wire logic             rd_ready,
	output dsss_pkg::entry_t      rd_data
);
	import dsss_pkg::*;

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	entry_t        mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_wr;
	logic          do_rd;

	assign wr_ready = (count_q != FULL_CNT);
	assign rd_valid = (count_q != '0);
	assign rd_data  = mem_q[rd_ptr_q];
	assign do_wr    = wr_valid && wr_ready;
	assign do_rd    = rd_valid && rd_ready;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/dsss_back.sv -----
// ----------------------------------------------------------------------------
// dsss_back
// Steps through the symbols of one queued byte and drives one chip word per
// symbol into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module dsss_back (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             pop_valid,
	output logic                                  pop_ready,
	input  wire dsss_pkg::entry_t                 pop_data,
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output logic [dsss_pkg::CHIP_W-1:0]           out_word,
	output logic [dsss_pkg::COUNT_W-1:0]          out_count,
	output logic                                  out_last
);
	import dsss_pkg::*;

	entry_t             cur_q;
	logic               cur_valid_q;
	logic [IDX_W-1:0]   idx_q;
	logic               out_valid_q;
	logic [CHIP_W-1:0]  out_word_q;
	logic [COUNT_W-1:0] out_count_q;
	logic               out_last_q;

	logic               adv;
	logic               last_sym;
	logic [3:0]         nib;
	logic [CHIP_W-1:0]  word;
	logic [COUNT_W-1:0] count;

	assign adv       = !out_valid_q || out_ready;
	assign last_sym  = (cur_q.kind == KIND_BPSK) ? (idx_q == BPSK_LAST_IDX)
	                                             : (idx_q == OQPSK_LAST_IDX);
	// take the next byte while the last symbol of this one goes out
	assign pop_ready = !cur_valid_q || (adv && last_sym);
	assign nib       = idx_q[0] ? cur_q.syms[7:4] : cur_q.syms[3:0];

	always_comb begin
		case (cur_q.kind)
			KIND_BPSK: begin
				word  = cur_q.syms[idx_q] ? BPSK_SEQ1 : BPSK_SEQ0;
				count = BPSK_CHIPS;
			end
			KIND_SUBGHZ: begin
				word  = subghz_chips(nib);
				count = SUBGHZ_CHIPS;
			end
			default: begin
				word  = wide_chips(nib);
				count = WIDE_CHIPS;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop_ready && pop_valid) begin
			cur_q <= pop_data;
		end
		if (adv && cur_valid_q) begin
			out_word_q  <= word;
			out_count_q <= count;
			out_last_q  <= last_sym;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				out_valid_q <= cur_valid_q;
			end
			if (pop_ready) begin
				cur_valid_q <= pop_valid;
			end
			// a fresh byte restarts at its first symbol
			if (pop_ready && pop_valid) begin
				idx_q <= '0;
			end else if (adv && cur_valid_q) begin
				idx_q <= last_sym ? '0 : idx_q + 1'b1;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;
	assign out_count = out_count_q;
	assign out_last  = out_last_q;

endmodule

`default_nettype wire

// ----- rtl/dsss_symbol_to_chip_spreader.sv -----
// ----------------------------------------------------------------------------
// dsss_symbol_to_chip_spreader
// IEEE 802.15.4 DSSS spreader: frame bytes in, one chip word per symbol out.
// ----------------------------------------------------------------------------
//  channel   dir  payload                                        end
//  s_axis    in   tdata[7:0] data_byte, tuser[0] frame_start     tvalid/tready
//  m_axis    out  tdata[31:0] chip_word, [37:32] chip_count,     tvalid/tready
//                 tlast last_of_byte
//  cfg       in   cfg_data[1:0] phy_mode                         cfg_valid/ready
//
//  One symbol word leaves per cycle while m_axis_tready is high; the back
//  end's symbol counter steps eight symbols per BPSK byte, two per O-QPSK.
//  An accepted byte passes the queue, current-byte and output registers.
//  Reset sets phy_mode to 32-chip O-QPSK and clears the differential bit.
//  A stalled m_axis fills the output register, then the queue, then drops
//  s_axis_tready. phy_mode changes apply to bytes accepted after the write.
// ----------------------------------------------------------------------------
`default_nettype none

module dsss_symbol_to_chip_spreader #(
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_data,       // phy_mode
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
	input  wire logic [0:0]  s_axis_tuser,   // [0] frame_start
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [39:0]      m_axis_tdata,   // [31:0] chip_word, [37:32] chip_count
	output logic             m_axis_tlast    // last_of_byte
);
	import dsss_pkg::*;

	entry_t             push_data;
	entry_t             pop_data;
	logic               push_valid;
	logic               push_ready;
	logic               pop_valid;
	logic               pop_ready;
	logic [CHIP_W-1:0]  chip_word;
	logic [COUNT_W-1:0] chip_count;

	dsss_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data),
		.in_valid       (s_axis_tvalid),
		.in_ready       (s_axis_tready),
		.in_byte        (s_axis_tdata),
		.in_frame_start (s_axis_tuser[0]),
		.push_valid     (push_valid),
		.push_ready     (push_ready),
		.push_data      (push_data)
	);

	dsss_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (push_valid),
		.wr_ready (push_ready),
		.wr_data  (push_data),
		.rd_valid (pop_valid),
		.rd_ready (pop_ready),
		.rd_data  (pop_data)
	);

	dsss_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_word  (chip_word),
		.out_count (chip_count),
		.out_last  (m_axis_tlast)
	);

	assign m_axis_tdata = {2'b00, chip_count, chip_word};

endmodule

`default_nettype wire

// ----- tb/tb_dsss_symbol_to_chip_spreader.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dsss_symbol_to_chip_spreader
// Feeds frame bytes through the spreader in every phy_mode and checks each
// chip word against a local model of the chip tables and differential coding,
// with random idle on the byte side and back-pressure on the word side.
// ----------------------------------------------------------------------------

module tb_dsss_symbol_to_chip_spreader;

	import dsss_pkg::*;

	localparam logic [MODE_W-1:0] PHY_MODE_SPARE = 2'd3;
	localparam int unsigned CLK_HALF    = 4;
	localparam int unsigned CYCLE_LIMIT = 300000;
	localparam int unsigned PHASE_BYTES = 52;

	// sub-GHz 16-chip sequences, chip 0 in bit 0
	localparam logic [15:0] SUBGHZ_SEQ [16] = '{
		16'hA47C, 16'h91F2, 16'h47CA, 16'h1F29, 16'h7CA4, 16'hF291, 16'hCA47, 16'h291F,
		16'h0ED6, 16'h3B58, 16'hED60, 16'hB583, 16'hD60E, 16'h583B, 16'h60ED, 16'h83B5
	};

	typedef struct packed {
		logic [CHIP_W-1:0]  chips;
		logic [COUNT_W-1:0] count;
		logic               last;
	} chip_word_t;

	class spread_model;
		logic [MODE_W-1:0] mode;
		logic              diff_bit;
		chip_word_t        pending_words[$];
		int                errors;
		int                checked;

		function new();
			mode     = PHY_MODE_RESET;
			diff_bit = 1'b0;
			errors   = 0;
			checked  = 0;
		endfunction

		function void set_mode(logic [MODE_W-1:0] m);
			mode = m;
		endfunction

		function logic [CHIP_W-1:0] wide_seq(logic [3:0] sym);
			logic [CHIP_W-1:0] w;
			int unsigned       rot;
			rot = sym[2:0] * 4;
			w   = (WIDE_BASE << rot) | (WIDE_BASE >> (32 - rot));
			if (sym[3]) begin
				w = w ^ WIDE_ODD_CHIPS;
			end
			return w;
		endfunction

		function void note_byte(logic [BYTE_W-1:0] b, logic start);
			chip_word_t  w;
			logic [3:0]  nib;
			int          k;
			if (start) begin
				diff_bit = 1'b0;
			end
			if (mode == PHY_MODE_BPSK) begin
				for (k = 0; k < 8; k++) begin
					diff_bit = b[k] ^ diff_bit;
					w.chips  = diff_bit ? BPSK_SEQ1 : BPSK_SEQ0;
					w.count  = BPSK_CHIPS;
					w.last   = (k == 7);
					pending_words.insert(pending_words.size(), w);
				end
			end else begin
				// low nibble first
				for (k = 0; k < 2; k++) begin
					nib    = b[k*4 +: 4];
					w.last = (k == 1);
					if (mode == PHY_MODE_SUBGHZ) begin
						w.chips = {16'h0000, SUBGHZ_SEQ[nib]};
						w.count = SUBGHZ_CHIPS;
					end else begin
						w.chips = wide_seq(nib);
						w.count = WIDE_CHIPS;
					end
					pending_words.insert(pending_words.size(), w);
				end
			end
		endfunction

		function void check_word(logic [CHIP_W-1:0] chips, logic [COUNT_W-1:0] count,
			logic last);
			chip_word_t want;
			if (pending_words.size() == 0) begin
				$error("chip word %h arrived with nothing expected", chips);
				errors++;
				return;
			end
			want = pending_words.pop_front();
			checked++;
			if (chips !== want.chips) begin
				$error("chip_word: expected %h, got %h", want.chips, chips);
				errors++;
			end
			if (count !== want.count) begin
				$error("chip_count: expected %0d, got %0d", want.count, count);
				errors++;
			end
			if (last !== want.last) begin
				$error("last_of_byte: expected %0b, got %0b", want.last, last);
				errors++;
			end
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [1:0]        cfg_data;         // phy_mode
	logic              s_axis_tvalid;
	logic              s_axis_tready;
	logic [7:0]        s_axis_tdata;     // [7:0] data_byte
	logic [0:0]        s_axis_tuser;     // [0] frame_start
	logic              m_axis_tvalid;
	logic              m_axis_tready;
	logic [39:0]       m_axis_tdata;     // [31:0] chip_word, [37:32] chip_count
	logic              m_axis_tlast;     // last_of_byte

	spread_model       sb;
	int unsigned       send_idle;
	int unsigned       recv_stall;
	int unsigned       cycles;
	int unsigned       bytes_sent;
	int unsigned       frames_sent;
	logic [3:0]        modes_seen;

	dsss_symbol_to_chip_spreader u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial begin
		clk = 1'b0;
		forever begin
			#CLK_HALF clk = ~clk;
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d words outstanding", cycles,
				sb.pending_words.size());
			$display("tb_dsss_symbol_to_chip_spreader: errors");
			$finish;
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			m_axis_tready <= ($urandom_range(99) >= recv_stall);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			sb.check_word(m_axis_tdata[31:0], m_axis_tdata[37:32], m_axis_tlast);
		end
	end

	// entered and left at a falling edge
	task automatic send_byte(input logic [7:0] b, input logic start);
		while ($urandom_range(99) < send_idle) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid   <= 1'b1;
		s_axis_tdata    <= b;
		s_axis_tuser[0] <= start;
		do begin
			@(posedge clk);
		end while (!s_axis_tready);
		sb.note_byte(b, start);
		bytes_sent++;
		if (start) begin
			frames_sent++;
		end
		@(negedge clk);
	endtask

	// drop valid, then hold until every word of the sent bytes is back
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (sb.pending_words.size() != 0) begin
			@(negedge clk);
		end
		repeat (4) @(negedge clk);
	endtask

	task automatic write_mode(input logic [MODE_W-1:0] m);
		settle();
		cfg_valid <= 1'b1;
		cfg_data  <= m;
		do begin
			@(posedge clk);
		end while (!cfg_ready);
		sb.set_mode(m);
		modes_seen[m] = 1'b1;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_frame(input int unsigned len);
		logic start;
		for (int unsigned i = 0; i < len; i++) begin
			start = (i == 0);
			// one byte in ten gets a random start mark
			if ($urandom_range(9) == 0) begin
				start = 1'($urandom_range(1));
			end
			send_byte(8'($urandom_range(255)), start);
		end
	endtask

	initial begin
		logic [MODE_W-1:0] phase_mode [8];
		int unsigned       phase_bytes;
		int unsigned       len;
		int unsigned       p;

		phase_mode    = '{PHY_MODE_BPSK, PHY_MODE_SUBGHZ, PHY_MODE_WIDE, PHY_MODE_SPARE,
			PHY_MODE_BPSK, PHY_MODE_WIDE, PHY_MODE_SUBGHZ, PHY_MODE_BPSK};
		sb            = new();
		arst_n        = 1'b0;
		cfg_valid     = 1'b0;
		cfg_data      = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = '0;
		m_axis_tready = 1'b0;
		send_idle     = 0;
		recv_stall    = 0;
		cycles        = 0;
		bytes_sent    = 0;
		frames_sent   = 0;
		modes_seen    = '0;

		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset mode: all sixteen 32-chip symbols
		send_byte(8'h10, 1'b1);
		send_byte(8'h32, 1'b0);
		send_byte(8'h54, 1'b0);
		send_byte(8'h76, 1'b0);
		send_byte(8'h98, 1'b0);
		send_byte(8'hBA, 1'b0);
		send_byte(8'hDC, 1'b0);
		send_byte(8'hFE, 1'b0);

		// all sixteen 16-chip symbols; a start mark must change nothing here
		write_mode(PHY_MODE_SUBGHZ);
		send_byte(8'hFE, 1'b1);
		send_byte(8'hDC, 1'b0);
		send_byte(8'hBA, 1'b0);
		send_byte(8'h98, 1'b1);
		send_byte(8'h76, 1'b0);
		send_byte(8'h54, 1'b0);
		send_byte(8'h32, 1'b0);
		send_byte(8'h10, 1'b0);

		// BPSK: the differential bit carries across bytes and across a mode change
		write_mode(PHY_MODE_BPSK);
		send_byte(8'h00, 1'b1);
		send_byte(8'hFF, 1'b0);
		write_mode(PHY_MODE_WIDE);
		send_byte(8'hA5, 1'b0);
		write_mode(PHY_MODE_BPSK);
		send_byte(8'h3C, 1'b0);
		send_byte(8'h96, 1'b1);

		// unused code runs as 32-chip O-QPSK
		write_mode(PHY_MODE_SPARE);
		send_byte(8'hF0, 1'b1);
		send_byte(8'h0F, 1'b0);

		for (p = 0; p < 8; p++) begin
			write_mode(phase_mode[p]);
			case (p % 4)
				0: begin
					send_idle  = 0;
					recv_stall = 0;
				end
				1: begin
					send_idle  = 61;
					recv_stall = 0;
				end
				2: begin
					send_idle  = 0;
					recv_stall = 61;
				end
				default: begin
					send_idle  = 17;
					recv_stall = 17;
				end
			endcase
			phase_bytes = 0;
			while (phase_bytes < PHASE_BYTES) begin
				len = ($urandom_range(7) == 0) ? $urandom_range(24, 12) : $urandom_range(6, 1);
				send_frame(len);
				phase_bytes += len;
			end
		end

		settle();
		repeat (20) @(negedge clk);
		if (sb.pending_words.size() != 0) begin
			$error("%0d chip words never arrived", sb.pending_words.size());
			sb.errors += sb.pending_words.size();
		end
		$display("%0d bytes in %0d frames spread, %0d chip words checked", bytes_sent,
			frames_sent, sb.checked);
		$display("phy_mode codes written (bit per code): %b, idle and stall up to 61%%",
			modes_seen);
		if (sb.errors == 0) begin
			$display("tb_dsss_symbol_to_chip_spreader: clean");
		end else begin
			$display("tb_dsss_symbol_to_chip_spreader: errors");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/dsss_pkg.sv
rtl/dsss_front.sv
rtl/dsss_queue.sv
rtl/dsss_back.sv
rtl/dsss_symbol_to_chip_spreader.sv
tb/tb_dsss_symbol_to_chip_spreader.sv
